// File: rtl/efbd_pkg.sv
// Package for the EWMA filter bank damping core.
// Holds field widths, function codes, register indexes and parameter defaults.
// No dependencies.
package efbd_pkg;

    // Q16.16 force and filter state width
    localparam int FORCE_WIDTH = 32;

    // Parameter defaults
    localparam int NUM_COMPONENTS_DEF = 64;
    localparam int NUM_FILTERS_DEF    = 4;

    // Item fields
    localparam int FUNC_W = 2;
    localparam int COMP_W = 6;

    localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COMMIT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REVERSE = 2'd2;

    // Configuration registers: four alphas, then four gains
    localparam int NUM_FILT_REGS = 4;
    localparam int FILT_SEL_W    = 2;
    localparam int ALPHA_W       = 16;
    localparam int GAIN_W        = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_0  = 3'd4;

    // Datapath widths
    localparam int DIFF_W  = FORCE_WIDTH + 1;           // force minus state
    localparam int PROD_A_W = ALPHA_W + 1 + DIFF_W;     // signed alpha times difference
    localparam int PROD_G_W = GAIN_W + DIFF_W;          // gain times difference
    localparam int RND_A_W  = PROD_A_W - 16;
    localparam int RND_G_W  = PROD_G_W - 16;
    localparam int SUM_W    = RND_G_W + FILT_SEL_W;     // room for four terms

endpackage

// File: rtl/ewma_filter_bank_damping_core.sv
// Usage
// Bank of first-order EWMA low-pass filters per component, giving a damping force.
// Input channel (in_valid / in_stall): func, component, force_req. A transaction
// is taken when in_valid is high and in_stall low. An update (func 0) reads the
// component's committed filter states, writes new trial states and returns one
// damping_force / saturated transaction on the output channel (out_valid /
// out_stall). A commit (func 1) copies all trial states to the committed store;
// a reverse (func 2) copies the other way. Neither returns a result; code 3 and
// updates for components out of range are dropped.
// Timing: an update streams one filter per cycle through the multiplier pair and
// occupies the core until its result is loaded into the output register, where
// it waits, so the next transaction is taken meanwhile. Commit and reverse walk
// all NUM_COMPONENTS * 2^ceil(log2 NUM_FILTERS) entries of the state store one
// entry per cycle, as the source memory has a single read port.
// Reset: the core runs a clearing pass over both stores, one entry per cycle,
// for the same number of entries (256 entries at the defaults); in_stall stays
// high meanwhile. Configuration writes (cfg_valid / cfg_ready, always ready) are
// taken at any time but should only be issued when idle.
// A stalled output holds its transaction; a finished update waits for it.
// Requires efbd_pkg and efbd_ram.
module ewma_filter_bank_damping_core #(
    parameter int NUM_COMPONENTS = efbd_pkg::NUM_COMPONENTS_DEF,
    parameter int NUM_FILTERS    = efbd_pkg::NUM_FILTERS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [efbd_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [efbd_pkg::CFG_DATA_W-1:0]           cfg_data,
    // input channel
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [efbd_pkg::FUNC_W-1:0]               func,
    input  logic [efbd_pkg::COMP_W-1:0]               component,
    input  logic signed [efbd_pkg::FORCE_WIDTH-1:0]   force_req,
    // output channel
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [efbd_pkg::FORCE_WIDTH-1:0]   damping_force,
    output logic                                      saturated
);

    import efbd_pkg::*;

    localparam int FILT_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
    localparam int CW     = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int DEPTH  = NUM_COMPONENTS * (2 ** FILT_W);
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [FILT_W-1:0] LAST_FILT = FILT_W'(NUM_FILTERS - 1);

    localparam logic signed [PROD_A_W-1:0] RND_A = PROD_A_W'(32768);
    localparam logic signed [PROD_G_W-1:0] RND_G = PROD_G_W'(32768);
    localparam logic signed [SUM_W-1:0]    SAT_HI = SUM_W'({1'b0, {(FORCE_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0]    SAT_LO = ~SAT_HI;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_ACC,
        S_DONE,
        S_WALK,
        S_DRAIN
    } state_t;

    state_t state_reg, state_next;

    // control
    logic [AW-1:0]     addr_reg, addr_next;
    logic [FILT_W-1:0] fj_reg, fj_next;
    logic              v1_reg, v1_next;
    logic              v2_reg, v3_reg;
    logic              wv1_reg, wv1_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              start_upd;
    logic              load_out;
    logic              comp_ok;

    // configuration registers
    logic [ALPHA_W-1:0]       alpha_reg [NUM_FILT_REGS];
    logic signed [GAIN_W-1:0] gain_reg  [NUM_FILT_REGS];

    // item and datapath
    logic [CW-1:0]                   comp_reg;
    logic signed [FORCE_WIDTH-1:0]   force_reg;
    logic                            dir_reg;    // high for commit
    logic [FILT_W-1:0]               f1_reg, f2_reg, f3_reg;
    logic [AW-1:0]                   waddr1_reg;
    logic signed [DIFF_W-1:0]        d2_reg;
    logic signed [FORCE_WIDTH-1:0]   c2_reg, c3_reg;
    logic signed [PROD_A_W-1:0]      pa3_reg;
    logic signed [PROD_G_W-1:0]      pg3_reg;
    logic signed [SUM_W-1:0]         sum_reg;
    logic signed [FORCE_WIDTH-1:0]   damping_force_reg;
    logic                            saturated_reg;

    logic signed [ALPHA_W:0]         alpha_s;
    logic signed [GAIN_W-1:0]        gain_s;
    logic signed [PROD_A_W-1:0]      pa_sum;
    logic signed [PROD_G_W-1:0]      pg_sum;
    logic signed [RND_A_W-1:0]       pa_rnd;
    logic signed [RND_G_W-1:0]       pg_rnd;
    logic signed [FORCE_WIDTH-1:0]   trial_new;

    // memories
    logic                   cst_wr_en, cst_rd_en;
    logic [AW-1:0]          cst_wr_addr, cst_rd_addr;
    logic [FORCE_WIDTH-1:0] cst_wr_data, cst_rd_data;
    logic                   trl_wr_en, trl_rd_en;
    logic [AW-1:0]          trl_wr_addr;
    logic [FORCE_WIDTH-1:0] trl_wr_data, trl_rd_data;
    logic [AW-1:0]          upd_rd_addr, upd_wr_addr;

    assign cfg_ready     = 1'b1;
    assign in_stall      = (state_reg != S_IDLE);
    assign accept        = in_valid && (state_reg == S_IDLE);
    assign comp_ok       = 32'(component) < 32'(NUM_COMPONENTS);
    assign out_valid     = out_valid_reg;
    assign damping_force = damping_force_reg;
    assign saturated     = saturated_reg;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        fj_next        = fj_reg;
        v1_next        = 1'b0;
        wv1_next       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        start_upd      = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_UPDATE && comp_ok)
                    begin
                        start_upd  = 1'b1;
                        fj_next    = '0;
                        state_next = S_ISSUE;
                    end
                    else if (func == FUNC_COMMIT || func == FUNC_REVERSE)
                    begin
                        addr_next  = '0;
                        state_next = S_WALK;
                    end
                end
            end
            S_ISSUE:
            begin
                // one committed-state read per filter
                v1_next = 1'b1;
                fj_next = fj_reg + 1'b1;
                if (fj_reg == LAST_FILT)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (v3_reg && f3_reg == LAST_FILT)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    load_out       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_WALK:
            begin
                wv1_next  = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            fj_reg        <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            wv1_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            fj_reg        <= fj_next;
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            wv1_reg       <= wv1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FILT_REGS; i++)
            begin
                alpha_reg[i] <= '0;
                gain_reg[i]  <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index < REG_GAIN_0)
            begin
                alpha_reg[FILT_SEL_W'(cfg_index - REG_ALPHA_0)] <= cfg_data[ALPHA_W-1:0];
            end
            else
            begin
                gain_reg[FILT_SEL_W'(cfg_index - REG_GAIN_0)] <= signed'(cfg_data[GAIN_W-1:0]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Update datapath: read, difference, multiply, round and accumulate
    // ---------------------------------------------------------------
    assign alpha_s = signed'({1'b0, alpha_reg[FILT_SEL_W'(f2_reg)]});
    assign gain_s  = gain_reg[FILT_SEL_W'(f2_reg)];

    // floor((p + 2^15) / 2^16) is the top bits of the rounded product
    assign pa_sum    = pa3_reg + RND_A;
    assign pg_sum    = pg3_reg + RND_G;
    assign pa_rnd    = pa_sum[PROD_A_W-1:16];
    assign pg_rnd    = pg_sum[PROD_G_W-1:16];
    assign trial_new = c3_reg + pa_rnd[FORCE_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            comp_reg  <= CW'(component);
            force_reg <= force_req;
            dir_reg   <= (func == FUNC_COMMIT);
        end
        f1_reg     <= fj_reg;
        waddr1_reg <= addr_reg;

        f2_reg <= f1_reg;
        c2_reg <= signed'(cst_rd_data);
        d2_reg <= DIFF_W'(force_reg) - DIFF_W'(signed'(cst_rd_data));

        f3_reg  <= f2_reg;
        c3_reg  <= c2_reg;
        pa3_reg <= alpha_s * d2_reg;
        pg3_reg <= gain_s * d2_reg;

        if (start_upd)
        begin
            sum_reg <= '0;
        end
        else if (v3_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(pg_rnd);
        end

        if (load_out)
        begin
            if (sum_reg > SAT_HI)
            begin
                damping_force_reg <= SAT_HI[FORCE_WIDTH-1:0];
                saturated_reg     <= 1'b1;
            end
            else if (sum_reg < SAT_LO)
            begin
                damping_force_reg <= SAT_LO[FORCE_WIDTH-1:0];
                saturated_reg     <= 1'b1;
            end
            else
            begin
                damping_force_reg <= sum_reg[FORCE_WIDTH-1:0];
                saturated_reg     <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // State stores
    // ---------------------------------------------------------------
    assign upd_rd_addr = AW'({comp_reg, fj_reg});
    assign upd_wr_addr = AW'({comp_reg, f3_reg});

    // committed store: read by updates and reverse, written by clear and commit
    assign cst_rd_en   = (state_reg == S_ISSUE) || (state_reg == S_WALK && !dir_reg);
    assign cst_rd_addr = (state_reg == S_ISSUE) ? upd_rd_addr : addr_reg;

    always_comb
    begin
        cst_wr_en   = 1'b0;
        cst_wr_addr = addr_reg;
        cst_wr_data = '0;
        if (state_reg == S_CLEAR)
        begin
            cst_wr_en = 1'b1;
        end
        else if (wv1_reg && dir_reg)
        begin
            cst_wr_en   = 1'b1;
            cst_wr_addr = waddr1_reg;
            cst_wr_data = trl_rd_data;
        end
    end

    // trial store: read by commit, written by clear, updates and reverse
    assign trl_rd_en = (state_reg == S_WALK) && dir_reg;

    always_comb
    begin
        trl_wr_en   = 1'b0;
        trl_wr_addr = addr_reg;
        trl_wr_data = '0;
        if (state_reg == S_CLEAR)
        begin
            trl_wr_en = 1'b1;
        end
        else if (v3_reg)
        begin
            trl_wr_en   = 1'b1;
            trl_wr_addr = upd_wr_addr;
            trl_wr_data = trial_new;
        end
        else if (wv1_reg && !dir_reg)
        begin
            trl_wr_en   = 1'b1;
            trl_wr_addr = waddr1_reg;
            trl_wr_data = cst_rd_data;
        end
    end

    efbd_ram #(
        .WIDTH (FORCE_WIDTH),
        .DEPTH (DEPTH)
    ) u_committed_ram (
        .clk     (clk),
        .wr_en   (cst_wr_en),
        .wr_addr (cst_wr_addr),
        .wr_data (cst_wr_data),
        .rd_en   (cst_rd_en),
        .rd_addr (cst_rd_addr),
        .rd_data (cst_rd_data)
    );

    efbd_ram #(
        .WIDTH (FORCE_WIDTH),
        .DEPTH (DEPTH)
    ) u_trial_ram (
        .clk     (clk),
        .wr_en   (trl_wr_en),
        .wr_addr (trl_wr_addr),
        .wr_data (trl_wr_data),
        .rd_en   (trl_rd_en),
        .rd_addr (addr_reg),
        .rd_data (trl_rd_data)
    );

endmodule

// File: rtl/efbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the trial and committed filter state stores. No dependencies.
module efbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
